[src/sftc_pkg.sv]
package sftc_pkg;

    localparam int CW    = 24;
    localparam int IW    = 24;
    localparam int OWNW  = 20;
    localparam int THW   = 16;
    localparam int CIW   = 3;
    localparam int CFGW  = (CW > THW) ? CW : THW;

    localparam int SW    = CW + 2;
    localparam int SVW   = CW + 3;
    localparam int TVW   = CW + 1;
    localparam int SMW   = CW + 2;
    localparam int TMW   = CW + 1;
    localparam int S2W   = 2 * SMW + 2;
    localparam int T2W   = 2 * TMW + 2;
    localparam int DW    = SMW + TMW + 2;
    localparam int DOTW  = DW + 1;
    localparam int DSQW  = 2 * DW;
    localparam int QF    = 2 * (THW - 1);
    localparam int RHSW  = 2 * THW + S2W + T2W;
    localparam int PW    = RHSW;
    localparam int BW    = S2W;
    localparam int CNTW  = $clog2(BW);
    localparam int OPW   = 4;

    localparam logic [1:0] CORNER_FIRST  = 2'd0;
    localparam logic [1:0] CORNER_SECOND = 2'd1;
    localparam logic [1:0] CORNER_LAST   = 2'd2;

    typedef enum logic [CIW-1:0] {
        CFG_CAMERA_X  = 3'd0,
        CFG_CAMERA_Y  = 3'd1,
        CFG_CAMERA_Z  = 3'd2,
        CFG_CENTER_X  = 3'd3,
        CFG_CENTER_Y  = 3'd4,
        CFG_CENTER_Z  = 3'd5,
        CFG_THRESHOLD = 3'd6
    } t_cfg_idx;

    typedef enum logic [OPW-1:0] {
        OP_SS0  = 4'd0,
        OP_SS1  = 4'd1,
        OP_SS2  = 4'd2,
        OP_TT0  = 4'd3,
        OP_TT1  = 4'd4,
        OP_TT2  = 4'd5,
        OP_ST0  = 4'd6,
        OP_ST1  = 4'd7,
        OP_ST2  = 4'd8,
        OP_DD   = 4'd9,
        OP_HH   = 4'd10,
        OP_RHS  = 4'd11,
        OP_RHT  = 4'd12
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_STEP,
        ST_STORE,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic signed [CW-1:0] pos_z;
        logic [IW-1:0]        vertex_index;
        logic [1:0]           corner;
        logic [OWNW-1:0]      owner_tag;
        logic                 owner_present;
    } t_in;

    typedef struct packed {
        logic [IW-1:0]   index_a;
        logic [IW-1:0]   index_b;
        logic [IW-1:0]   index_c;
        logic [OWNW-1:0] owner_out;
        logic            owner_valid;
    } t_out;

    typedef struct packed {
        logic accept;
        logic start;
        logic step;
        logic store;
        logic out_load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic visible;
        logic out_free;
    } t_sts;

endpackage

[src/sftc_controller.sv]
module sftc_controller (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_last,
    input  sftc_pkg::t_sts  i_sts,
    output sftc_pkg::t_cmd  o_cmd,
    output logic            o_stall
);

    sftc_pkg::t_state              r_state, n_state;
    sftc_pkg::t_op                 r_op, n_op;
    logic [sftc_pkg::CNTW-1:0]     r_cnt, n_cnt;
    logic                          cnt_done;
    logic                          op_done;

    assign cnt_done = (r_cnt == sftc_pkg::CNTW'(sftc_pkg::BW - 1));
    assign op_done  = (r_op == sftc_pkg::OP_RHT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sftc_pkg::ST_IDLE: begin
                if (i_valid && i_last) begin
                    n_state = sftc_pkg::ST_START;
                end
            end
            sftc_pkg::ST_START: begin
                n_state = sftc_pkg::ST_STEP;
            end
            sftc_pkg::ST_STEP: begin
                if (cnt_done) begin
                    n_state = sftc_pkg::ST_STORE;
                end
            end
            sftc_pkg::ST_STORE: begin
                n_state = op_done ? sftc_pkg::ST_DECIDE : sftc_pkg::ST_START;
            end
            sftc_pkg::ST_DECIDE: begin
                if (!i_sts.visible || i_sts.out_free) begin
                    n_state = sftc_pkg::ST_IDLE;
                end
            end
            default: n_state = sftc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = r_op;
        o_stall        = 1'b1;
        n_op           = r_op;
        n_cnt          = r_cnt;
        unique case (r_state)
            sftc_pkg::ST_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
                n_op         = sftc_pkg::OP_SS0;
            end
            sftc_pkg::ST_START: begin
                o_cmd.start = 1'b1;
                n_cnt       = '0;
            end
            sftc_pkg::ST_STEP: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
            end
            sftc_pkg::ST_STORE: begin
                o_cmd.store = 1'b1;
                if (!op_done) begin
                    n_op = sftc_pkg::t_op'(r_op + 1'b1);
                end
            end
            sftc_pkg::ST_DECIDE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sftc_pkg::ST_IDLE;
            r_op    <= sftc_pkg::OP_SS0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[src/sftc_datapath.sv]
module sftc_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sftc_pkg::CIW-1:0]    i_cfg_idx,
    input  logic [sftc_pkg::CFGW-1:0]   i_cfg_data,
    input  sftc_pkg::t_in               i_in,
    input  sftc_pkg::t_cmd              i_cmd,
    input  logic                        i_out_stall,
    output sftc_pkg::t_sts              o_sts,
    output logic                        o_valid,
    output sftc_pkg::t_out              o_out
);

    logic signed [sftc_pkg::CW-1:0]   r_cam [3];
    logic signed [sftc_pkg::CW-1:0]   r_ctr [3];
    logic signed [sftc_pkg::THW-1:0]  r_th;

    logic [sftc_pkg::SW-1:0]          r_sum [3];
    logic [sftc_pkg::IW-1:0]          r_first;
    logic [sftc_pkg::IW-1:0]          r_second;
    logic [sftc_pkg::IW-1:0]          r_idx_c;
    logic [sftc_pkg::OWNW-1:0]        r_owner;
    logic                             r_present;

    logic signed [sftc_pkg::SVW-1:0]  r_s [3];
    logic signed [sftc_pkg::TVW-1:0]  r_t [3];

    logic [sftc_pkg::PW-1:0]          r_a;
    logic [sftc_pkg::BW-1:0]          r_b;
    logic [sftc_pkg::PW-1:0]          r_p;
    logic [sftc_pkg::S2W-1:0]         r_s2;
    logic [sftc_pkg::T2W-1:0]         r_t2;
    logic signed [sftc_pkg::DOTW-1:0] r_dot;
    logic [sftc_pkg::DSQW-1:0]        r_dsq;
    logic [sftc_pkg::RHSW-1:0]        r_rhs;

    sftc_pkg::t_out                   r_out;
    logic                             r_out_valid;

    logic signed [sftc_pkg::CW-1:0]   pos [3];
    logic [sftc_pkg::SW-1:0]          sum_nxt [3];
    logic signed [sftc_pkg::SVW-1:0]  s_nxt [3];
    logic signed [sftc_pkg::TVW-1:0]  t_nxt [3];
    logic signed [sftc_pkg::SVW-1:0]  s_neg [3];
    logic signed [sftc_pkg::TVW-1:0]  t_neg [3];
    logic [sftc_pkg::SMW-1:0]         s_mag [3];
    logic [sftc_pkg::TMW-1:0]         t_mag [3];
    logic signed [sftc_pkg::DOTW-1:0] dot_neg_val;
    logic [sftc_pkg::DW-1:0]          dot_mag;
    logic signed [sftc_pkg::THW-1:0]  th_neg_val;
    logic [sftc_pkg::THW-1:0]         th_mag;
    logic signed [sftc_pkg::DOTW-1:0] prod_d;
    logic [sftc_pkg::PW-1:0]          op_a;
    logic [sftc_pkg::BW-1:0]          op_b;
    logic                             dot_sub;
    logic [sftc_pkg::PW-1:0]          lhs;
    logic                             s_zero;
    logic                             t_zero;
    logic                             dot_neg;
    logic                             th_neg;
    logic                             visible;
    logic                             out_free;

    always_comb begin
        pos[0] = i_in.pos_x;
        pos[1] = i_in.pos_y;
        pos[2] = i_in.pos_z;
        for (int k = 0; k < 3; k++) begin
            sum_nxt[k] = r_sum[k] + {{2{pos[k][sftc_pkg::CW-1]}}, pos[k]};
            s_nxt[k]   = $signed({sum_nxt[k][sftc_pkg::SW-1], sum_nxt[k]})
                       - ($signed({{3{r_ctr[k][sftc_pkg::CW-1]}}, r_ctr[k]})
                       +  $signed({{2{r_ctr[k][sftc_pkg::CW-1]}}, r_ctr[k], 1'b0}));
            t_nxt[k]   = $signed({r_cam[k][sftc_pkg::CW-1], r_cam[k]})
                       - $signed({r_ctr[k][sftc_pkg::CW-1], r_ctr[k]});
            s_neg[k]   = -r_s[k];
            t_neg[k]   = -r_t[k];
            s_mag[k]   = r_s[k][sftc_pkg::SVW-1] ? s_neg[k][sftc_pkg::SMW-1:0]
                                                 : r_s[k][sftc_pkg::SMW-1:0];
            t_mag[k]   = r_t[k][sftc_pkg::TVW-1] ? t_neg[k][sftc_pkg::TMW-1:0]
                                                 : r_t[k][sftc_pkg::TMW-1:0];
        end
    end

    assign dot_neg     = r_dot[sftc_pkg::DOTW-1];
    assign dot_neg_val = -r_dot;
    assign dot_mag     = dot_neg ? dot_neg_val[sftc_pkg::DW-1:0] : r_dot[sftc_pkg::DW-1:0];
    assign th_neg      = r_th[sftc_pkg::THW-1];
    assign th_neg_val  = -r_th;
    assign th_mag      = th_neg ? th_neg_val : r_th;
    assign prod_d      = $signed({1'b0, r_p[sftc_pkg::DW-1:0]});

    always_comb begin
        op_a    = '0;
        op_b    = '0;
        dot_sub = 1'b0;
        unique case (i_cmd.op)
            sftc_pkg::OP_SS0: begin
                op_a = sftc_pkg::PW'(s_mag[0]);
                op_b = sftc_pkg::BW'(s_mag[0]);
            end
            sftc_pkg::OP_SS1: begin
                op_a = sftc_pkg::PW'(s_mag[1]);
                op_b = sftc_pkg::BW'(s_mag[1]);
            end
            sftc_pkg::OP_SS2: begin
                op_a = sftc_pkg::PW'(s_mag[2]);
                op_b = sftc_pkg::BW'(s_mag[2]);
            end
            sftc_pkg::OP_TT0: begin
                op_a = sftc_pkg::PW'(t_mag[0]);
                op_b = sftc_pkg::BW'(t_mag[0]);
            end
            sftc_pkg::OP_TT1: begin
                op_a = sftc_pkg::PW'(t_mag[1]);
                op_b = sftc_pkg::BW'(t_mag[1]);
            end
            sftc_pkg::OP_TT2: begin
                op_a = sftc_pkg::PW'(t_mag[2]);
                op_b = sftc_pkg::BW'(t_mag[2]);
            end
            sftc_pkg::OP_ST0: begin
                op_a    = sftc_pkg::PW'(s_mag[0]);
                op_b    = sftc_pkg::BW'(t_mag[0]);
                dot_sub = r_s[0][sftc_pkg::SVW-1] ^ r_t[0][sftc_pkg::TVW-1];
            end
            sftc_pkg::OP_ST1: begin
                op_a    = sftc_pkg::PW'(s_mag[1]);
                op_b    = sftc_pkg::BW'(t_mag[1]);
                dot_sub = r_s[1][sftc_pkg::SVW-1] ^ r_t[1][sftc_pkg::TVW-1];
            end
            sftc_pkg::OP_ST2: begin
                op_a    = sftc_pkg::PW'(s_mag[2]);
                op_b    = sftc_pkg::BW'(t_mag[2]);
                dot_sub = r_s[2][sftc_pkg::SVW-1] ^ r_t[2][sftc_pkg::TVW-1];
            end
            sftc_pkg::OP_DD: begin
                op_a = sftc_pkg::PW'(dot_mag);
                op_b = sftc_pkg::BW'(dot_mag);
            end
            sftc_pkg::OP_HH: begin
                op_a = sftc_pkg::PW'(th_mag);
                op_b = sftc_pkg::BW'(th_mag);
            end
            sftc_pkg::OP_RHS: begin
                op_a = r_rhs;
                op_b = r_s2;
            end
            sftc_pkg::OP_RHT: begin
                op_a = r_rhs;
                op_b = sftc_pkg::BW'(r_t2);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign s_zero = (r_s[0] == '0) && (r_s[1] == '0) && (r_s[2] == '0);
    assign t_zero = (r_t[0] == '0) && (r_t[1] == '0) && (r_t[2] == '0);
    assign lhs    = {{(sftc_pkg::PW - sftc_pkg::DSQW - sftc_pkg::QF){1'b0}},
                     r_dsq, {sftc_pkg::QF{1'b0}}};

    always_comb begin
        if (s_zero || t_zero) begin
            visible = th_neg;
        end else if (!dot_neg) begin
            visible = th_neg || (lhs > r_rhs);
        end else begin
            visible = th_neg && (lhs < r_rhs);
        end
    end

    assign out_free       = !r_out_valid || !i_out_stall;
    assign o_sts.visible  = visible;
    assign o_sts.out_free = out_free;
    assign o_valid        = r_out_valid;
    assign o_out          = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_cam[k] <= '0;
                r_ctr[k] <= '0;
            end
            r_th <= '0;
        end else if (i_cfg_we) begin
            unique case (sftc_pkg::t_cfg_idx'(i_cfg_idx))
                sftc_pkg::CFG_CAMERA_X:  r_cam[0] <= i_cfg_data[sftc_pkg::CW-1:0];
                sftc_pkg::CFG_CAMERA_Y:  r_cam[1] <= i_cfg_data[sftc_pkg::CW-1:0];
                sftc_pkg::CFG_CAMERA_Z:  r_cam[2] <= i_cfg_data[sftc_pkg::CW-1:0];
                sftc_pkg::CFG_CENTER_X:  r_ctr[0] <= i_cfg_data[sftc_pkg::CW-1:0];
                sftc_pkg::CFG_CENTER_Y:  r_ctr[1] <= i_cfg_data[sftc_pkg::CW-1:0];
                sftc_pkg::CFG_CENTER_Z:  r_ctr[2] <= i_cfg_data[sftc_pkg::CW-1:0];
                sftc_pkg::CFG_THRESHOLD: r_th     <= i_cfg_data[sftc_pkg::THW-1:0];
                default: r_th <= r_th;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
            end
            r_first  <= '0;
            r_second <= '0;
        end else if (i_cmd.accept) begin
            unique case (i_in.corner)
                sftc_pkg::CORNER_FIRST: begin
                    for (int k = 0; k < 3; k++) begin
                        r_sum[k] <= {{2{pos[k][sftc_pkg::CW-1]}}, pos[k]};
                    end
                    r_first <= i_in.vertex_index;
                end
                sftc_pkg::CORNER_SECOND: begin
                    r_sum    <= sum_nxt;
                    r_second <= i_in.vertex_index;
                end
                sftc_pkg::CORNER_LAST: begin
                    r_sum <= sum_nxt;
                end
                default: r_first <= r_first;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_in.corner == sftc_pkg::CORNER_LAST)) begin
            r_s       <= s_nxt;
            r_t       <= t_nxt;
            r_idx_c   <= i_in.vertex_index;
            r_owner   <= i_in.owner_present ? i_in.owner_tag : '0;
            r_present <= i_in.owner_present;
        end
        if (i_cmd.start) begin
            r_a <= op_a;
            r_b <= op_b;
            r_p <= '0;
        end else if (i_cmd.step) begin
            if (r_b[0]) begin
                r_p <= r_p + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
        if (i_cmd.store) begin
            unique case (i_cmd.op)
                sftc_pkg::OP_SS0: r_s2 <= r_p[sftc_pkg::S2W-1:0];
                sftc_pkg::OP_SS1,
                sftc_pkg::OP_SS2: r_s2 <= r_s2 + r_p[sftc_pkg::S2W-1:0];
                sftc_pkg::OP_TT0: r_t2 <= r_p[sftc_pkg::T2W-1:0];
                sftc_pkg::OP_TT1,
                sftc_pkg::OP_TT2: r_t2 <= r_t2 + r_p[sftc_pkg::T2W-1:0];
                sftc_pkg::OP_ST0: r_dot <= dot_sub ? -prod_d : prod_d;
                sftc_pkg::OP_ST1,
                sftc_pkg::OP_ST2: r_dot <= dot_sub ? r_dot - prod_d : r_dot + prod_d;
                sftc_pkg::OP_DD:  r_dsq <= r_p[sftc_pkg::DSQW-1:0];
                sftc_pkg::OP_HH,
                sftc_pkg::OP_RHS,
                sftc_pkg::OP_RHT: r_rhs <= r_p;
                default: r_rhs <= r_rhs;
            endcase
        end
        if (i_cmd.out_load && visible) begin
            r_out.index_a     <= r_first;
            r_out.index_b     <= r_second;
            r_out.index_c     <= r_idx_c;
            r_out.owner_out   <= r_owner;
            r_out.owner_valid <= r_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load && visible) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

[src/sphere_facing_triangle_cull_top.sv]
// Corner 0 and corner 1 transfers are taken one per cycle with no result while no decision
// stalls the input. A corner 2 transfer starts a decision that stalls the input until it ends:
// thirteen products through one shift-add multiplier of 54 bits, each a start, shift-add steps
// and a store, then a compare. A visible triangle's result is then registered at the output;
// the stall lasts longer while an earlier result is still held by the output stall.
// Reset is synchronous and active low; it clears the configuration, sums and first two indices.
module sphere_facing_triangle_cull_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sftc_pkg::CIW-1:0]    i_cfg_idx,
    input  logic [sftc_pkg::CFGW-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  sftc_pkg::t_in               i_in,
    output logic                        o_valid,
    input  logic                        i_stall,
    output sftc_pkg::t_out              o_out
);

    sftc_pkg::t_cmd cmd;
    sftc_pkg::t_sts sts;
    logic           last;

    assign last = (i_in.corner == sftc_pkg::CORNER_LAST);

    sftc_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (last),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    sftc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_stall (i_stall),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .o_out       (o_out)
    );

endmodule

[src/sftc_checker.sv]
module sftc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input sftc_pkg::t_in  i_in,
    input logic           o_valid,
    input logic           i_stall,
    input sftc_pkg::t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_out))
        else $error("stalled result changed");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_in.corner == sftc_pkg::CORNER_LAST) |=> o_stall)
        else $error("input not stalled after a closing corner");

    a_free_after_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_in.corner != sftc_pkg::CORNER_LAST) |=> !o_stall)
        else $error("input stalled after a leading corner");

endmodule

bind sphere_facing_triangle_cull_top sftc_checker u_sftc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_in    (i_in),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);
